// File: sv/generational_handle_table_macros.svh
// ----------------------------------------------------------------------------
// generational handle table assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

// checked only outside reset
`define GHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("generational handle table check failed");

// checked during reset too
`define GHT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("generational handle table reset check failed");

`endif

// File: sv/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// types, codes and widths of the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;
  localparam int GEN_BITS   = 8;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int ID_W       = 9;
  localparam int POS_W      = 8;
  localparam int OP_W       = 3;
  localparam int STAT_W     = 2;
  localparam int IN_W       = 64;
  localparam int OUT_W      = 64;

  typedef logic [ID_W-1:0]       id_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [GEN_BITS-1:0]   gen_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [OP_W-1:0]       op_t;
  typedef logic [STAT_W-1:0]     stat_t;

  localparam op_t OP_ACQUIRE = 3'd0;
  localparam op_t OP_DISCARD = 3'd1;
  localparam op_t OP_GET     = 3'd2;
  localparam op_t OP_SET     = 3'd3;
  localparam op_t OP_ITERATE = 3'd4;
  localparam op_t OP_CLEAR   = 3'd5;

  localparam stat_t ST_OK   = 2'd0;
  localparam stat_t ST_BAD  = 2'd1;
  localparam stat_t ST_FULL = 2'd2;
  localparam stat_t ST_END  = 2'd3;

endpackage

// File: sv/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// File: sv/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// slot map with generational handles over four single-port-read rams
// ----------------------------------------------------------------------------
// One word is taken at a time, and none while a result word waits on the
// output. Clear, unused codes, handles out of range, a full table and an
// iteration past the end finish in S_RD1, acquire in S_RD2, set and
// iterate in S_RD3, get in S_RD4; discard ends in S_FREE, after S_MOVE when
// the last entry moves into the hole. A failed generation or back-reference
// check ends in S_RD2 or S_RD3. The steps follow the chain of dependent ram
// reads (slot link, back-reference, last owner) through one registered read
// port per ram. The next word is taken at the earliest on the edge after
// the result is raised, and only once it has been taken or is taken there.
module generational_handle_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // opcode, handle_index, handle_generation, data_word, packed_position
  input  logic [ght_pkg::IN_W-1:0]  s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // status, result_index, result_generation, result_word, live_entries
  output logic [ght_pkg::OUT_W-1:0] m_tdata
);
  import ght_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_RD3  = 3'd3;
  localparam logic [2:0] S_RD4  = 3'd4;
  localparam logic [2:0] S_MOVE = 3'd5;
  localparam logic [2:0] S_FREE = 3'd6;

  logic [2:0] state, state_next;
  op_t    op;
  id_t    hid;
  gen_t   hgen;
  value_t word;
  logic [POS_W-1:0] ppos;
  id_t    pos, pos_next;
  gen_t   slot_gen, slot_gen_next;
  slot_t  owner, owner_next;
  value_t value, value_next;
  id_t    free_head, free_head_next;
  id_t    live, live_next;
  id_t    touched, touched_next;

  logic   finish;
  stat_t  res_status;
  id_t    res_idx;
  gen_t   res_gen;
  value_t res_word;

  stat_t  out_status;
  id_t    out_idx;
  gen_t   out_gen;
  value_t out_word;
  id_t    out_live;

  logic   link_we, gen_we, owner_we, store_we;
  slot_t  link_wa, gen_wa, owner_wa, store_wa;
  id_t    link_wd;
  gen_t   gen_wd;
  slot_t  owner_wd;
  value_t store_wd;
  slot_t  link_ra, gen_ra, owner_ra, store_ra;
  id_t    link_rd;
  gen_t   gen_rd;
  slot_t  owner_rd;
  value_t store_rd;

  logic   accept;
  slot_t  hslot, fslot;
  id_t    last;
  logic   in_range;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign hslot    = SLOT_W'(hid - 1'b1);
  assign fslot    = free_head[SLOT_W-1:0];
  assign last     = live - 1'b1;
  assign in_range = (hid != '0) && (hid <= touched);

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    slot_gen_next  = slot_gen;
    owner_next     = owner;
    value_next     = value;
    free_head_next = free_head;
    live_next      = live;
    touched_next   = touched;
    finish         = 1'b0;
    res_status     = ST_OK;
    res_idx        = '0;
    res_gen        = '0;
    res_word       = '0;
    link_we  = 1'b0;
    gen_we   = 1'b0;
    owner_we = 1'b0;
    store_we = 1'b0;
    link_wa  = hslot;
    gen_wa   = hslot;
    owner_wa = live[SLOT_W-1:0];
    store_wa = live[SLOT_W-1:0];
    link_wd  = '0;
    gen_wd   = '0;
    owner_wd = fslot;
    store_wd = word;
    link_ra  = (op == OP_ACQUIRE) ? fslot : hslot;
    gen_ra   = link_ra;
    owner_ra = ppos;
    store_ra = ppos;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        case (op)
          OP_ACQUIRE: begin
            if (live >= ID_W'(CAPACITY) || free_head >= ID_W'(CAPACITY)) begin
              res_status = ST_FULL;
              finish     = 1'b1;
            end else begin
              state_next = S_RD2;
            end
          end
          OP_DISCARD, OP_GET, OP_SET: begin
            if (!in_range) begin
              res_status = ST_BAD;
              finish     = 1'b1;
            end else begin
              state_next = S_RD2;
            end
          end
          OP_ITERATE: begin
            if (ID_W'(ppos) >= live) begin
              res_status = ST_END;
              finish     = 1'b1;
            end else begin
              state_next = S_RD2;
            end
          end
          OP_CLEAR: begin
            free_head_next = '0;
            live_next      = '0;
            touched_next   = '0;
            finish         = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_RD2: begin
        case (op)
          OP_ACQUIRE: begin
            owner_we = 1'b1;
            store_we = 1'b1;
            link_we  = 1'b1;
            link_wa  = fslot;
            link_wd  = live;
            live_next = live + 1'b1;
            res_idx   = free_head + 1'b1;
            if (free_head >= touched) begin
              gen_we         = 1'b1;
              gen_wa         = fslot;
              gen_wd         = '0;
              touched_next   = free_head + 1'b1;
              free_head_next = free_head + 1'b1;
              res_gen        = '0;
            end else begin
              free_head_next = link_rd;
              res_gen        = gen_rd;
            end
            finish = 1'b1;
          end
          OP_ITERATE: begin
            owner_next = owner_rd;
            value_next = store_rd;
            gen_ra     = owner_rd;
            state_next = S_RD3;
          end
          default: begin
            slot_gen_next = gen_rd;
            pos_next      = link_rd;
            owner_ra      = link_rd[SLOT_W-1:0];
            if (gen_rd != hgen || link_rd >= live) begin
              res_status = ST_BAD;
              finish     = 1'b1;
            end else begin
              state_next = S_RD3;
            end
          end
        endcase
      end
      S_RD3: begin
        if (op == OP_ITERATE) begin
          res_idx  = ID_W'(owner) + 1'b1;
          res_gen  = gen_rd;
          res_word = value;
          finish   = 1'b1;
        end else if (owner_rd != hslot) begin
          res_status = ST_BAD;
          finish     = 1'b1;
        end else begin
          case (op)
            OP_GET: begin
              store_ra   = pos[SLOT_W-1:0];
              state_next = S_RD4;
            end
            OP_SET: begin
              store_we = 1'b1;
              store_wa = pos[SLOT_W-1:0];
              finish   = 1'b1;
            end
            default: begin
              live_next  = last;
              owner_ra   = last[SLOT_W-1:0];
              store_ra   = last[SLOT_W-1:0];
              state_next = (pos < last) ? S_MOVE : S_FREE;
            end
          endcase
        end
      end
      S_RD4: begin
        res_word = store_rd;
        finish   = 1'b1;
      end
      S_MOVE: begin
        owner_we   = 1'b1;
        owner_wa   = pos[SLOT_W-1:0];
        owner_wd   = owner_rd;
        store_we   = 1'b1;
        store_wa   = pos[SLOT_W-1:0];
        store_wd   = store_rd;
        link_we    = 1'b1;
        link_wa    = owner_rd;
        link_wd    = pos;
        state_next = S_FREE;
      end
      S_FREE: begin
        link_we        = 1'b1;
        link_wd        = free_head;
        gen_we         = 1'b1;
        gen_wd         = slot_gen + 1'b1;
        free_head_next = ID_W'(hslot);
        finish         = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      live      <= '0;
      touched   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      live      <= live_next;
      touched   <= touched_next;
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= s_tdata[2:0];
      hid  <= s_tdata[11:3];
      hgen <= s_tdata[19:12];
      word <= s_tdata[51:20];
      ppos <= s_tdata[59:52];
    end
    pos      <= pos_next;
    slot_gen <= slot_gen_next;
    owner    <= owner_next;
    value    <= value_next;
    if (finish) begin
      out_status <= res_status;
      out_idx    <= res_idx;
      out_gen    <= res_gen;
      out_word   <= res_word;
      out_live   <= live_next;
    end
  end

  assign m_tdata = {4'b0, out_live, out_word, out_gen, out_idx, out_status};

  ght_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(link_we), .wa(link_wa), .wd(link_wd), .ra(link_ra), .rd(link_rd)
  );

  ght_ram #(.WIDTH(GEN_BITS), .DEPTH(CAPACITY)) u_gen (
    .clk(clk), .we(gen_we), .wa(gen_wa), .wd(gen_wd), .ra(gen_ra), .rd(gen_rd)
  );

  ght_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_owner (
    .clk(clk), .we(owner_we), .wa(owner_wa), .wd(owner_wd), .ra(owner_ra), .rd(owner_rd)
  );

  ght_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_store (
    .clk(clk), .we(store_we), .wa(store_wa), .wd(store_wd), .ra(store_ra), .rd(store_rd)
  );

endmodule

// File: sv/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// port-level checks of the generational handle table
// ----------------------------------------------------------------------------
`include "generational_handle_table_macros.svh"

module ght_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [ght_pkg::OUT_W-1:0] m_tdata
);
  import ght_pkg::*;

  `GHT_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid)
  `GHT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `GHT_ASSERT(a_no_take_when_blocked, m_tvalid && !m_tready |-> !s_tready)
  `GHT_ASSERT(a_no_instant_result, s_tvalid && s_tready |=> !m_tvalid)
  `GHT_ASSERT(a_live_bound, m_tvalid |-> m_tdata[59:51] <= ID_W'(CAPACITY))

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);
